FILE: design/cqss_pkg.sv
package cqss_pkg;

    typedef enum logic [1:0] {
        KIND_INIT      = 2'd0,
        KIND_RECOMPUTE = 2'd1,
        KIND_NEXT      = 2'd2,
        KIND_UPDATE    = 2'd3
    } kind_t;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned MAG_W  = 63;
    localparam logic [63:0] Q_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_MIN  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [62:0] quo;
    } div_rsp_t;

    // signed add of an unsigned magnitude, saturating
    function automatic logic [63:0] add_mag(input logic [63:0] a, input logic [63:0] m);
        logic [64:0] s;
        begin
            s = {1'b0, a ^ Q_MIN} + {1'b0, m};
            add_mag = s[64] ? Q_MAX : (s[63:0] ^ Q_MIN);
        end
    endfunction

    function automatic logic [63:0] sub_mag(input logic [63:0] a, input logic [63:0] m);
        logic [64:0] s;
        begin
            s = {1'b0, a ^ Q_MIN} - {1'b0, m};
            sub_mag = s[64] ? Q_MIN : (s[63:0] ^ Q_MIN);
        end
    endfunction

endpackage

FILE: design/cqss_ram.sv
module cqss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/cqss_div.sv
// Restoring radix-2 divider: (num << 32) / den, one bit per cycle, 96 steps.
module cqss_div (
    input  logic                clk,
    input  logic                rst_n,
    input  cqss_pkg::div_req_t  req,
    output cqss_pkg::div_rsp_t  rsp
);
    import cqss_pkg::*;

    logic [95:0] dividend_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [62:0] quo_reg;
    logic        over_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] shifted;
    logic        take;
    logic [63:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dividend_reg[95]};
        take     = shifted >= {1'b0, den_reg};
        rem_next = take ? 64'(shifted - {1'b0, den_reg}) : shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg     <= 1'b1;
                cnt_reg      <= 7'd95;
                dividend_reg <= {req.num, 32'd0};
                den_reg      <= req.den;
                rem_reg      <= '0;
                quo_reg      <= '0;
                over_reg     <= 1'b0;
            end
            else if (busy_reg)
            begin
                rem_reg      <= rem_next;
                dividend_reg <= {dividend_reg[94:0], 1'b0};
                if (take && cnt_reg >= 7'd63)
                begin
                    over_reg <= 1'b1;
                end
                quo_reg <= {quo_reg[61:0], take & (cnt_reg < 7'd63)};
                if (cnt_reg == 7'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = over_reg ? Q_MAX[62:0] : quo_reg;
endmodule

FILE: design/centered_qss_quantizer_top.sv
// Centered QSS quantizer, one band per variable, signed Q32.32.
// Input channel: in_valid/in_stall with kind, var_index, now_time,
// state_value, state_slope, quantized_in, quantum. An item transfers when
// in_valid is high and in_stall is low. Output channel: out_valid/out_stall
// with next_time, never_flag, quantized_out; a result transfers when
// out_valid is high and out_stall is low.
// Config: cfg_valid/cfg_ready writes epsilon_threshold; write only when idle.
// Path: init, update, zero slope and out-of-range items go from S_READ
// through S_EXEC and S_WAIT to S_OUT; crossing items also pass S_DIV,
// the 96-step bit-serial divider. One item at a time; in_stall is high
// while busy, so the next transfer waits until the block is back in
// S_IDLE, which an output stall can delay.
// A held result in the output register does not block the next item, but a
// second result waits until the first has been taken.
// Reset: correction flag cleared, epsilon_threshold = 1, nothing pending.
// Bound and time stores are RAMs that are undefined until written.
module centered_qss_quantizer_top #(
    parameter int VARIABLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [5:0]  var_index,
    input  logic signed [63:0] now_time,
    input  logic signed [63:0] state_value,
    input  logic signed [63:0] state_slope,
    input  logic signed [63:0] quantized_in,
    input  logic [62:0] quantum,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [63:0] next_time,
    output logic        never_flag,
    output logic signed [63:0] quantized_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [62:0] cfg_data
);
    import cqss_pkg::*;

    localparam int AW = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_DIV, S_WAIT, S_OUT
    } state_t;

    state_t      state_reg;
    logic [62:0] eps_reg;
    logic        pend_reg;
    logic [1:0]  kind_reg;
    logic [AW-1:0] addr_reg;
    logic        inrange_reg;
    logic [63:0] t_reg, x_reg, s_reg, q_reg;
    logic [63:0] dq_reg;
    logic [63:0] nt_reg, qo_reg;
    logic        nv_reg;
    logic        ovalid_reg;

    logic [63:0] ub_rd, lb_rd, tm_rd;
    logic        ub_we, lb_we, tm_we;
    logic [63:0] ub_wd, lb_wd;
    div_req_t    dreq;
    div_rsp_t    drsp;

    logic        accept;
    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    cqss_ram #(.WIDTH(64), .DEPTH(VARIABLES)) u_ub (
        .clk(clk), .we(ub_we), .waddr(addr_reg), .wdata(ub_wd),
        .raddr(addr_reg), .rdata(ub_rd));
    cqss_ram #(.WIDTH(64), .DEPTH(VARIABLES)) u_lb (
        .clk(clk), .we(lb_we), .waddr(addr_reg), .wdata(lb_wd),
        .raddr(addr_reg), .rdata(lb_rd));
    cqss_ram #(.WIDTH(64), .DEPTH(VARIABLES)) u_tm (
        .clk(clk), .we(tm_we), .waddr(addr_reg), .wdata(t_reg),
        .raddr(addr_reg), .rdata(tm_rd));

    cqss_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // execute-stage combinational work, from registered RAM data and registered inputs
    logic        s_pos, s_neg, s_zero, away, narrow;
    logic [63:0] s_abs, dq2, dq_half;
    logic [63:0] e_ub, e_lb, e_q, up_ub, dn_lb, bnd, adiff;
    logic        e_pend;
    logic        xl;
    always_comb
    begin
        s_pos   = !s_reg[63] && (s_reg != 64'd0);
        s_neg   = s_reg[63];
        s_zero  = (s_reg == 64'd0);
        s_abs   = s_neg ? 64'(-s_reg) : s_reg;
        dq2     = {dq_reg[62:0], 1'b0};
        dq_half = {1'b0, dq_reg[63:1]};
        away    = (s_pos && ($signed(q_reg) < $signed(x_reg)))
               || (s_neg && ($signed(q_reg) > $signed(x_reg)));
        narrow  = (tm_rd == t_reg) && away && (s_abs > {1'b0, eps_reg});
        up_ub   = add_mag(ub_rd, dq_reg);
        dn_lb   = sub_mag(lb_rd, dq_reg);
        e_ub    = ub_rd;
        e_lb    = lb_rd;
        e_q     = q_reg;
        e_pend  = pend_reg;
        ub_we   = 1'b0;
        lb_we   = 1'b0;
        tm_we   = 1'b0;
        if (state_reg == S_EXEC && inrange_reg)
        begin
            unique case (kind_t'(kind_reg))
                KIND_INIT:
                begin
                    e_q    = x_reg;
                    e_ub   = add_mag(x_reg, dq_reg);
                    e_lb   = sub_mag(x_reg, dq_reg);
                    e_pend = 1'b0;
                    ub_we  = 1'b1;
                    lb_we  = 1'b1;
                    tm_we  = 1'b1;
                end
                KIND_RECOMPUTE:
                begin
                    if (narrow)
                    begin
                        e_pend = 1'b1;
                        e_lb   = add_mag(lb_rd, dq_reg);
                        e_ub   = sub_mag(ub_rd, dq_reg);
                        ub_we  = 1'b1;
                        lb_we  = 1'b1;
                    end
                end
                KIND_NEXT:
                begin
                end
                KIND_UPDATE:
                begin
                    tm_we = 1'b1;
                    ub_we = 1'b1;
                    lb_we = 1'b1;
                    if (pend_reg)
                    begin
                        e_q    = x_reg;
                        e_ub   = add_mag(x_reg, dq_reg);
                        e_lb   = sub_mag(x_reg, dq_reg);
                        e_pend = 1'b0;
                    end
                    else if (s_pos)
                    begin
                        e_ub = up_ub;
                        e_q  = sub_mag(up_ub, dq_half);
                        e_lb = sub_mag(up_ub, dq2);
                    end
                    else if (s_neg)
                    begin
                        e_lb = dn_lb;
                        e_q  = add_mag(dn_lb, dq_half);
                        e_ub = add_mag(dn_lb, dq2);
                    end
                end
                default:
                begin
                end
            endcase
        end
        ub_wd = e_ub;
        lb_wd = e_lb;
        bnd   = s_pos ? e_ub : e_lb;
        xl    = (bnd ^ Q_MIN) >= (x_reg ^ Q_MIN);
        adiff = xl ? 64'((bnd ^ Q_MIN) - (x_reg ^ Q_MIN))
                   : 64'((x_reg ^ Q_MIN) - (bnd ^ Q_MIN));
    end

    logic need_div;
    assign need_div = inrange_reg && !s_zero
                   && (kind_reg == KIND_RECOMPUTE || kind_reg == KIND_NEXT);
    assign dreq.start = (state_reg == S_EXEC) && need_div;
    assign dreq.num   = adiff;
    assign dreq.den   = s_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            eps_reg    <= 63'd1;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        eps_reg <= cfg_data;
                    end
                    if (accept)
                    begin
                        kind_reg    <= kind;
                        addr_reg    <= AW'(var_index);
                        inrange_reg <= {26'd0, var_index} < 32'(VARIABLES);
                        t_reg       <= now_time;
                        x_reg       <= state_value;
                        s_reg       <= state_slope;
                        q_reg       <= quantized_in;
                        dq_reg      <= {1'b0, quantum};
                        state_reg   <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    pend_reg <= e_pend;
                    qo_reg   <= e_q;
                    nt_reg   <= 64'd0;
                    nv_reg   <= 1'b0;
                    if (inrange_reg && s_zero
                        && (kind_reg == KIND_RECOMPUTE || kind_reg == KIND_NEXT))
                    begin
                        nt_reg <= Q_MAX;
                        nv_reg <= 1'b1;
                    end
                    state_reg <= need_div ? S_DIV : S_WAIT;
                end
                S_DIV:
                begin
                    if (drsp.done)
                    begin
                        nt_reg    <= add_mag(t_reg, {1'b0, drsp.quo});
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    next_time     <= nt_reg;
                    never_flag    <= nv_reg;
                    quantized_out <= qo_reg;
                    ovalid_reg    <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = ovalid_reg;

    // S_OUT only entered with output register free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !ovalid_reg)
        else $error("output overwrite");
    a_div_only: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_DIV)
        else $error("divider done outside S_DIV");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("accepted while busy");
endmodule
